// ===== hw/rtl/spbls_pkg.sv =====
// Package for the shared-pin button and LED scanner: payload types and codes.
package spbls_pkg;

  // Input actions
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_SET_ONE = 2'd1;
  localparam logic [1:0] ACT_SET_ALL = 2'd2;

  // Event kinds
  localparam logic [1:0] KIND_HELD     = 2'd0;
  localparam logic [1:0] KIND_PRESSED  = 2'd1;
  localparam logic [1:0] KIND_RELEASED = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_PIN_COUNT    = 2'd0;
  localparam logic [1:0] REG_SCAN_GAP     = 2'd1;
  localparam logic [1:0] REG_CYCLE_GAP    = 2'd2;
  localparam logic [1:0] REG_BLINK_PERIOD = 2'd3;

  // Register reset values
  localparam logic [3:0]  PIN_COUNT_RST    = 4'd8;
  localparam logic [15:0] SCAN_GAP_RST     = 16'd10;
  localparam logic [15:0] CYCLE_GAP_RST    = 16'd10;
  localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] led_index;
    logic       led_on;
    logic       led_blink;
    logic       readback_dark;
    logic       readback_probe;
  } in_t;

  typedef struct packed {
    logic       event_valid;
    logic [2:0] button_index;
    logic [1:0] event_kind;
    logic [7:0] pin_levels;
    logic [7:0] led_mask;
    logic [7:0] blink_mask;
  } out_t;

endpackage

// ===== hw/rtl/shared_pin_button_led_scanner.sv =====
// Shared-pin button and LED scanner: input stage, step logic, state and result register.
// Takes one transaction per cycle while the result side keeps up: an accepted item
// is held in the input register, then a single pass of bit-vector logic updates
// the scan, LED and blink state and loads the result register. A tick scans at
// most one pin (two readback samples carried in the item) and runs the blink
// timer; LED commands set one or all pins in use. pin_levels, led_mask and
// blink_mask show the state left by the item whose result is presented. Registers
// sit at byte addresses 0x0 pin_count, 0x4 scan_gap_ms, 0x8 cycle_gap_ms, 0xC
// blink_period_ms; write them only while idle.
module shared_pin_button_led_scanner #(
  parameter int PINS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spbls_pkg::in_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spbls_pkg::out_t    out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import spbls_pkg::*;

  localparam int IDXW = (PINS > 1) ? $clog2(PINS) : 1;
  localparam int CW   = $clog2(PINS + 1);

  // Configuration
  logic [3:0]  pin_count_q;
  logic [15:0] scan_gap_q, cycle_gap_q, blink_period_q;
  logic        cfg_wr;

  // Input stage and result register
  logic        in_valid_q, out_valid_q, advance;
  in_t         in_q;
  logic        ev_valid_q, ev_valid_d;
  logic [2:0]  ev_btn_q, ev_btn_d;
  logic [1:0]  ev_kind_q, ev_kind_d;

  // Scanner state
  logic [IDXW-1:0] scan_idx_q, scan_idx_d;
  logic [PINS-1:0] pressed_q, pressed_d;
  logic [PINS-1:0] led_q, led_d;
  logic [PINS-1:0] blink_q, blink_d;
  logic [PINS-1:0] pin_q, pin_d;
  logic            phase_q, phase_d;
  logic [15:0]     scan_wait_q, scan_wait_d;
  logic [15:0]     blink_wait_q, blink_wait_d;

  // Step logic
  logic [CW-1:0]   count;
  logic [PINS-1:0] use_mask, rest, scan_sel, led_sel;
  logic [IDXW-1:0] scan_n;
  logic [IDXW:0]   scan_next;
  logic [31:0]     scan_n_ext;
  logic            was_pressed, now_pressed;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3:2])
      REG_PIN_COUNT:    prdata = {28'd0, pin_count_q};
      REG_SCAN_GAP:     prdata = {16'd0, scan_gap_q};
      REG_CYCLE_GAP:    prdata = {16'd0, cycle_gap_q};
      REG_BLINK_PERIOD: prdata = {16'd0, blink_period_q};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_count_q    <= PIN_COUNT_RST;
      scan_gap_q     <= SCAN_GAP_RST;
      cycle_gap_q    <= CYCLE_GAP_RST;
      blink_period_q <= BLINK_PERIOD_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PIN_COUNT:    pin_count_q    <= pwdata[3:0];
        REG_SCAN_GAP:     scan_gap_q     <= pwdata[15:0];
        REG_CYCLE_GAP:    cycle_gap_q    <= pwdata[15:0];
        REG_BLINK_PERIOD: blink_period_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Advance the input stage when the result register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Clamp pin_count to 1..PINS.
  always_comb begin
    if (pin_count_q == 4'd0) begin
      count = CW'(1);
    end else if (32'(pin_count_q) > PINS) begin
      count = CW'(PINS);
    end else begin
      count = CW'(pin_count_q);
    end
  end

  assign scan_n     = (32'(scan_idx_q) >= 32'(count)) ? '0 : scan_idx_q;
  assign scan_next  = {1'b0, scan_n} + {{IDXW{1'b0}}, 1'b1};
  assign scan_n_ext = 32'(scan_n);

  always_comb begin
    for (int i = 0; i < PINS; i++) begin
      use_mask[i] = (i < 32'(count));
      rest[i]     = blink_q[i] ? phase_q : led_q[i];
      scan_sel[i] = (scan_n_ext == i);
      led_sel[i]  = (32'(in_q.led_index) == i) && (i < 32'(count));
    end
  end

  assign was_pressed = |(pressed_q & scan_sel);
  assign now_pressed = !in_q.readback_dark && !in_q.readback_probe;

  always_comb begin
    scan_idx_d   = scan_idx_q;
    pressed_d    = pressed_q;
    led_d        = led_q;
    blink_d      = blink_q;
    pin_d        = pin_q;
    phase_d      = phase_q;
    scan_wait_d  = scan_wait_q;
    blink_wait_d = blink_wait_q;
    ev_valid_d   = 1'b0;
    ev_btn_d     = 3'd0;
    ev_kind_d    = KIND_HELD;
    case (in_q.action)
      ACT_TICK: begin
        if (scan_wait_q <= 16'd1) begin
          // Probe drive is transient: only the restored levels remain.
          if (!in_q.readback_dark) begin
            pin_d = (pin_q & ~use_mask) | (rest & use_mask);
          end else begin
            pin_d = (pin_q & ~scan_sel) | (rest & scan_sel);
          end
          if (now_pressed) begin
            ev_valid_d = 1'b1;
            ev_btn_d   = scan_n_ext[2:0];
            ev_kind_d  = was_pressed ? KIND_HELD : KIND_PRESSED;
            pressed_d  = pressed_q | scan_sel;
          end else if (was_pressed) begin
            ev_valid_d = 1'b1;
            ev_btn_d   = scan_n_ext[2:0];
            ev_kind_d  = KIND_RELEASED;
            pressed_d  = pressed_q & ~scan_sel;
          end
          if (32'(scan_next) >= 32'(count)) begin
            scan_idx_d  = '0;
            scan_wait_d = cycle_gap_q;
          end else begin
            scan_idx_d  = scan_next[IDXW-1:0];
            scan_wait_d = scan_gap_q;
          end
        end else begin
          scan_wait_d = scan_wait_q - 16'd1;
        end
        if (blink_wait_q <= 16'd1) begin
          pin_d = (pin_d & ~(blink_q & use_mask))
                | ({PINS{phase_q}} & blink_q & use_mask);
          phase_d      = ~phase_q;
          blink_wait_d = blink_period_q;
        end else begin
          blink_wait_d = blink_wait_q - 16'd1;
        end
      end
      ACT_SET_ONE: begin
        if (in_q.led_on) begin
          pin_d   = pin_q | led_sel;
          led_d   = led_q | led_sel;
          blink_d = blink_q | (led_sel & {PINS{in_q.led_blink}});
        end else begin
          pin_d   = pin_q & ~led_sel;
          led_d   = led_q & ~led_sel;
          blink_d = blink_q & ~led_sel;
        end
      end
      ACT_SET_ALL: begin
        if (in_q.led_on) begin
          pin_d = pin_q | use_mask;
          led_d = led_q | use_mask;
        end else begin
          pin_d   = pin_q & ~use_mask;
          led_d   = led_q & ~use_mask;
          blink_d = blink_q & ~use_mask;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      scan_idx_q   <= '0;
      pressed_q    <= '0;
      led_q        <= '0;
      blink_q      <= '0;
      pin_q        <= '0;
      phase_q      <= 1'b0;
      scan_wait_q  <= 16'd0;
      blink_wait_q <= BLINK_PERIOD_RST;
    end else begin
      if (advance) begin
        out_valid_q  <= 1'b1;
        scan_idx_q   <= scan_idx_d;
        pressed_q    <= pressed_d;
        led_q        <= led_d;
        blink_q      <= blink_d;
        pin_q        <= pin_d;
        phase_q      <= phase_d;
        scan_wait_q  <= scan_wait_d;
        blink_wait_q <= blink_wait_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_valid_q <= ev_valid_d;
      ev_btn_q   <= ev_btn_d;
      ev_kind_q  <= ev_kind_d;
    end
  end

  // State only moves when the result register loads, so the masks are its payload.
  logic [7:0] pin8, led8, blink8;

  for (genvar k = 0; k < 8; k++) begin : g_out
    if (k < PINS) begin : g_pin
      assign pin8[k]   = pin_q[k];
      assign led8[k]   = led_q[k];
      assign blink8[k] = blink_q[k];
    end else begin : g_pad
      assign pin8[k]   = 1'b0;
      assign led8[k]   = 1'b0;
      assign blink8[k] = 1'b0;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.event_valid  = ev_valid_q;
  assign out_data_o.button_index = ev_btn_q;
  assign out_data_o.event_kind   = ev_kind_q;
  assign out_data_o.pin_levels   = pin8;
  assign out_data_o.led_mask     = led8;
  assign out_data_o.blink_mask   = blink8;

  a_blink_within_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blink_q & ~led_q) == '0)
    else $error("blink bit set on a dark LED");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with an empty result register");

  a_no_press_when_dark_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.action == ACT_TICK && in_q.readback_dark
    |=> !(out_data_o.event_valid && out_data_o.event_kind != KIND_RELEASED))
    else $error("press reported without a low first sample");

  a_quiet_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.event_valid
    |-> out_data_o.button_index == 3'd0 && out_data_o.event_kind == KIND_HELD)
    else $error("event fields set on a result without an event");

endmodule
